@@ hw/rtl/assert_macros.svh @@
// assertion helpers, clocked on i_clk and disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define PTT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// implication check built on the plain form
`define PTT_ASSERT_IMPL(lbl, ante, cons, msg) \
    `PTT_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

@@ hw/rtl/ptt_pkg.sv @@
`default_nettype none

package ptt_pkg;

    // widths of the fixed fields, and the queue depth
    localparam int unsigned IDX_W   = 13;
    localparam int unsigned ENTRY_W = 16;
    localparam int unsigned PAGE_W  = 14;
    localparam int unsigned OFS_W   = 15;
    localparam int unsigned OFF_W   = 26;
    localparam int unsigned Q_DEPTH = 2;

    // address decode constants
    localparam logic [31:0]      PERM_MASK      = 32'hCCEF_EEFF;
    localparam logic [31:0]      BUS_MASK       = 32'h03FF_FFFF;
    localparam logic [OFF_W-1:0] CTRL_AREA_MASK = 26'h3E0_0000;
    localparam logic [OFF_W-1:0] CTRL_AREA      = 26'h360_0000;
    localparam logic [31:0]      HIGH_ADDR_MASK = 32'hFE00_0000;
    localparam logic [2:0]       CTRL_REG_SEL   = 3'h7;

    // what the back end does with an item
    typedef enum logic [1:0] {
        OP_NONE,
        OP_TRANSLATE,
        OP_CTRL,
        OP_TABLE
    } t_op_kind;

    // classified item handed from front to back
    typedef struct packed {
        t_op_kind             kind;
        logic                 mapped;
        logic [IDX_W-1:0]     index;
        logic [ENTRY_W-1:0]   entry;
        logic [1:0]           size_code;
        logic [OFS_W-1:0]     offset;
        logic                 is_write;
        logic                 privileged;
        logic                 video_en;
        logic                 sound_en;
        logic                 os_mode;
        logic                 test_fault;
    } t_op;

endpackage

`default_nettype wire

@@ hw/rtl/ptt_front.sv @@
`default_nettype none

module ptt_front #(
    parameter int unsigned TABLE_DEPTH = 8192,
    parameter logic [31:0] CAM_BASE    = 32'd58720256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_cmd,
    input  wire logic [31:0]   i_address,
    input  wire logic          i_is_write,
    input  wire logic          i_privileged,
    output logic               o_ready,
    input  wire logic          i_q_ready,
    input  wire logic          i_init_busy,
    output logic               o_push,
    output ptt_pkg::t_op       o_op
);

    localparam logic [15:0] D1 = 16'(TABLE_DEPTH);
    localparam logic [15:0] D2 = 16'(2 * TABLE_DEPTH);
    localparam logic [15:0] D4 = 16'(4 * TABLE_DEPTH);

    logic [1:0]                  r_page_size;
    logic [1:0]                  n_page_size;
    logic                        accept;
    logic [ptt_pkg::OFF_W-1:0]   off;
    ptt_pkg::t_op_kind           kind;
    logic [6:0]                  pp7;
    logic [1:0]                  chip;
    logic [ptt_pkg::IDX_W-1:0]   tbl_lp;
    logic [ptt_pkg::IDX_W-1:0]   tr_lp;
    logic [ptt_pkg::IDX_W-1:0]   lp_raw;
    logic [15:0]                 v0;
    logic [15:0]                 v1;
    logic [15:0]                 v2;
    logic [15:0]                 v3;

    // handshake
    assign o_ready = i_q_ready && !i_init_busy;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;

    // classify the item
    always_comb begin
        off = ptt_pkg::OFF_W'(i_address & ptt_pkg::BUS_MASK);
        priority if (!i_cmd) begin
            kind = ptt_pkg::OP_TRANSLATE;
        end else if (off < ptt_pkg::CTRL_AREA) begin
            kind = ptt_pkg::OP_NONE;
        end else if ((off & ptt_pkg::CTRL_AREA_MASK) == ptt_pkg::CTRL_AREA) begin
            kind = (off[19:17] == ptt_pkg::CTRL_REG_SEL) ? ptt_pkg::OP_CTRL
                                                         : ptt_pkg::OP_NONE;
        end else if ({6'b0, off} >= CAM_BASE) begin
            kind = ptt_pkg::OP_TABLE;
        end else begin
            kind = ptt_pkg::OP_NONE;
        end
    end

    // page table write field scramble, by page size
    always_comb begin
        unique case (r_page_size)
            2'd0: begin
                pp7    = off[6:0];
                chip   = {1'b0, off[7]};
                tbl_lp = {off[11:10], off[22:12]};
            end
            2'd1: begin
                pp7    = {off[0], off[6:1]};
                chip   = {off[12], off[7]};
                tbl_lp = {1'b0, off[11:10], off[22:13]};
            end
            2'd2: begin
                pp7    = {off[1:0], off[6:2]};
                chip   = {off[12], off[7]};
                tbl_lp = {2'b0, off[11:10], off[22:14]};
            end
            default: begin
                pp7    = {off[1], off[2], off[0], off[6:3]};
                chip   = {off[12], off[7]};
                tbl_lp = {3'b0, off[11:10], off[22:15]};
            end
        endcase
    end

    // logical page and wrap into the table
    always_comb begin
        tr_lp  = i_address[24:12] >> r_page_size;
        lp_raw = (kind == ptt_pkg::OP_TABLE) ? tbl_lp : tr_lp;
        v0 = 16'(lp_raw);
        v1 = (v0 >= D4) ? v0 - D4 : v0;
        v2 = (v1 >= D2) ? v1 - D2 : v1;
        v3 = (v2 >= D1) ? v2 - D1 : v2;
    end

    // build the queued item
    always_comb begin
        o_op.kind       = kind;
        o_op.mapped     = (i_address & ptt_pkg::HIGH_ADDR_MASK) == 32'd0;
        o_op.index      = v3[ptt_pkg::IDX_W-1:0];
        o_op.entry      = {off[9:8], 5'b0, chip, pp7};
        o_op.size_code  = r_page_size;
        o_op.offset     = i_address[ptt_pkg::OFS_W-1:0] &
                          (15'h7FFF >> (2'd3 - r_page_size));
        o_op.is_write   = i_is_write;
        o_op.privileged = i_privileged;
        o_op.video_en   = off[10];
        o_op.sound_en   = off[11];
        o_op.os_mode    = off[12];
        o_op.test_fault = off[13];
    end

    // page size is tracked here so later items decode in order
    always_comb begin
        n_page_size = r_page_size;
        if (accept && kind == ptt_pkg::OP_CTRL) begin
            n_page_size = off[3:2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size <= 2'd0;
        end else begin
            r_page_size <= n_page_size;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ptt_queue.sv @@
`default_nettype none

module ptt_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ptt_pkg::t_op  i_op,
    output logic               o_ready,
    input  wire logic          i_pop,
    output logic               o_valid,
    output ptt_pkg::t_op       o_op
);

    localparam int unsigned PW = $clog2(ptt_pkg::Q_DEPTH);
    localparam int unsigned CW = $clog2(ptt_pkg::Q_DEPTH + 1);

    ptt_pkg::t_op    r_slot [ptt_pkg::Q_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            do_push;
    logic            do_pop;

    assign o_ready = r_count != CW'(ptt_pkg::Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_op    = r_slot[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // occupancy
    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ptt_back.sv @@
`default_nettype none

module ptt_back #(
    parameter int unsigned TABLE_DEPTH    = 8192,
    parameter logic [31:0] PHYS_RAM_BASE  = 32'd33554432,
    parameter logic [31:0] RESET_ROM_BASE = 32'd54525952
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire ptt_pkg::t_op  i_q_op,
    output logic               o_q_pop,
    output logic               o_init_busy,
    input  wire logic          i_m_ready,
    output logic               o_m_valid,
    output logic               o_has_mapping,
    output logic               o_access_allowed,
    output logic [31:0]        o_phys_addr,
    output logic               o_test_mode_fault,
    output logic               o_video_dma_on,
    output logic               o_sound_dma_on
);

    localparam int unsigned IW = $clog2(TABLE_DEPTH);
    localparam logic [31:0] ROM_OFFSET = RESET_ROM_BASE - PHYS_RAM_BASE;
    localparam logic [ptt_pkg::PAGE_W-1:0] INIT_PAGE = ROM_OFFSET[25:12];

    logic [ptt_pkg::ENTRY_W-1:0] mem [TABLE_DEPTH];

    logic                        r_init_busy;
    logic [IW-1:0]               r_init_cnt;
    logic                        r_os;
    logic                        r_video;
    logic                        r_sound;
    logic                        n_video;
    logic                        n_sound;
    logic                        r_b_valid;
    ptt_pkg::t_op                r_b_op;
    logic                        r_b_video;
    logic                        r_b_sound;
    logic                        r_b_os;
    logic [ptt_pkg::ENTRY_W-1:0] r_rd_data;
    logic                        r_out_valid;
    logic                        r_out_mapped;
    logic                        r_out_allowed;
    logic [31:0]                 r_out_phys;
    logic                        r_out_fault;
    logic                        r_out_video;
    logic                        r_out_sound;

    logic                        out_free;
    logic                        b_adv;
    logic                        pop;
    logic                        mem_we;
    logic [IW-1:0]               mem_waddr;
    logic [ptt_pkg::ENTRY_W-1:0] mem_wdata;
    logic                        mem_re;
    logic                        res_mapped;
    logic                        res_allowed;
    logic [31:0]                 res_phys;
    logic                        res_fault;
    logic [4:0]                  perm_idx;
    logic [3:0]                  shift_amt;

    // flow control between queue, lookup stage and output register
    assign out_free    = !r_out_valid || i_m_ready;
    assign b_adv       = r_b_valid && out_free;
    assign pop         = i_q_valid && !r_init_busy && (!r_b_valid || out_free);
    assign o_q_pop     = pop;
    assign o_init_busy = r_init_busy;

    // table port: clearing pass first, then entry writes
    always_comb begin
        mem_we    = r_init_busy || (pop && i_q_op.kind == ptt_pkg::OP_TABLE);
        mem_waddr = r_init_busy ? r_init_cnt : i_q_op.index[IW-1:0];
        mem_wdata = r_init_busy ? {2'b01, INIT_PAGE + ptt_pkg::PAGE_W'(r_init_cnt)}
                                : i_q_op.entry;
        mem_re    = pop && i_q_op.kind == ptt_pkg::OP_TRANSLATE && i_q_op.mapped;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[i_q_op.index[IW-1:0]];
        end
    end

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_busy <= 1'b1;
            r_init_cnt  <= '0;
        end else if (r_init_busy) begin
            r_init_cnt <= r_init_cnt + IW'(1);
            if (r_init_cnt == IW'(TABLE_DEPTH - 1)) begin
                r_init_busy <= 1'b0;
            end
        end
    end

    // control register
    always_comb begin
        n_video = r_video;
        n_sound = r_sound;
        if (pop && i_q_op.kind == ptt_pkg::OP_CTRL) begin
            n_video = i_q_op.video_en;
            n_sound = i_q_op.sound_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_os    <= 1'b0;
            r_video <= 1'b0;
            r_sound <= 1'b0;
        end else begin
            r_video <= n_video;
            r_sound <= n_sound;
            if (pop && i_q_op.kind == ptt_pkg::OP_CTRL) begin
                r_os <= i_q_op.os_mode;
            end
        end
    end

    // lookup stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (pop) begin
            r_b_valid <= 1'b1;
        end else if (b_adv) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_b_op    <= i_q_op;
            r_b_video <= n_video;
            r_b_sound <= n_sound;
            r_b_os    <= r_os;
        end
    end

    // result from the entry read
    always_comb begin
        perm_idx  = {r_b_op.is_write, r_rd_data[15:14], r_b_op.privileged, r_b_os};
        shift_amt = 4'd12 + 4'(r_b_op.size_code);
        unique case (r_b_op.kind)
            ptt_pkg::OP_TRANSLATE: begin
                res_mapped  = r_b_op.mapped;
                res_allowed = r_b_op.mapped && ptt_pkg::PERM_MASK[perm_idx];
                res_phys    = r_b_op.mapped
                    ? (((32'(r_rd_data[ptt_pkg::PAGE_W-1:0]) << shift_amt)
                        | 32'(r_b_op.offset)) + PHYS_RAM_BASE)
                    : 32'd0;
                res_fault   = 1'b0;
            end
            ptt_pkg::OP_CTRL: begin
                res_mapped  = 1'b0;
                res_allowed = 1'b0;
                res_phys    = 32'd0;
                res_fault   = r_b_op.test_fault;
            end
            default: begin
                res_mapped  = 1'b0;
                res_allowed = 1'b0;
                res_phys    = 32'd0;
                res_fault   = 1'b0;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_out_mapped  <= res_mapped;
            r_out_allowed <= res_allowed;
            r_out_phys    <= res_phys;
            r_out_fault   <= res_fault;
            r_out_video   <= r_b_video;
            r_out_sound   <= r_b_sound;
        end
    end

    assign o_m_valid         = r_out_valid;
    assign o_has_mapping     = r_out_mapped;
    assign o_access_allowed  = r_out_allowed;
    assign o_phys_addr       = r_out_phys;
    assign o_test_mode_fault = r_out_fault;
    assign o_video_dma_on    = r_out_video;
    assign o_sound_dma_on    = r_out_sound;

endmodule

`default_nettype wire

@@ hw/rtl/page_table_translator_with_protection_top.sv @@
// Page translator with per-page protection.
// Input stream s_axis: tuser selects the kind (0 translate, 1 controller
// bus write); tdata carries the address, the write flag and the privilege
// flag. Output stream m_axis: one result transfer for every input transfer,
// in order, with mapping flag, access verdict, physical address, test mode
// fault and the current video and sound DMA enables.
// Path: queue, lookup stage, output register. Throughput: one item per cycle
// unless the receiver stalls; the page table is a single memory with one
// write and one registered read port, used by one item per cycle.
// Reset: the table is loaded with the ROM mapping by a clearing pass over all
// TABLE_DEPTH entries (8192 by default), one per cycle; s_axis_tready
// stays low while it runs. Control state resets to 4 KB pages, DMA off.
// Receiver stall: the output register holds its result; the lookup stage and
// a two-entry queue absorb further items, then s_axis_tready drops.
`default_nettype none
`include "assert_macros.svh"

module page_table_translator_with_protection_top #(
    parameter int unsigned TABLE_DEPTH    = 8192,
    parameter logic [31:0] PHYS_RAM_BASE  = 32'd33554432,
    parameter logic [31:0] CAM_BASE       = 32'd58720256,
    parameter logic [31:0] RESET_ROM_BASE = 32'd54525952
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // [31:0] address, [32] is_write, [33] privileged, [39:34] zero
    input  wire logic [39:0]   s_axis_tdata,
    // [0] cmd
    input  wire logic          s_axis_tuser,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // [0] has_mapping, [1] access_allowed, [33:2] phys_addr,
    // [34] test_mode_fault, [35] video_dma_on, [36] sound_dma_on, [39:37] zero
    output logic [39:0]        m_axis_tdata
);

    logic          q_ready;
    logic          q_push;
    ptt_pkg::t_op  front_op;
    logic          q_valid;
    logic          q_pop;
    ptt_pkg::t_op  q_op;
    logic          init_busy;
    logic          has_mapping;
    logic          access_allowed;
    logic [31:0]   phys_addr;
    logic          test_mode_fault;
    logic          video_dma_on;
    logic          sound_dma_on;

    // decode and classify
    ptt_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CAM_BASE    (CAM_BASE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_cmd        (s_axis_tuser),
        .i_address    (s_axis_tdata[31:0]),
        .i_is_write   (s_axis_tdata[32]),
        .i_privileged (s_axis_tdata[33]),
        .o_ready      (s_axis_tready),
        .i_q_ready    (q_ready),
        .i_init_busy  (init_busy),
        .o_push       (q_push),
        .o_op         (front_op)
    );

    // decoupling queue
    ptt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (front_op),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    // table access and result
    ptt_back #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .PHYS_RAM_BASE  (PHYS_RAM_BASE),
        .RESET_ROM_BASE (RESET_ROM_BASE)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_op            (q_op),
        .o_q_pop           (q_pop),
        .o_init_busy       (init_busy),
        .i_m_ready         (m_axis_tready),
        .o_m_valid         (m_axis_tvalid),
        .o_has_mapping     (has_mapping),
        .o_access_allowed  (access_allowed),
        .o_phys_addr       (phys_addr),
        .o_test_mode_fault (test_mode_fault),
        .o_video_dma_on    (video_dma_on),
        .o_sound_dma_on    (sound_dma_on)
    );

    // result packing
    assign m_axis_tdata = {3'b000, sound_dma_on, video_dma_on, test_mode_fault,
                           phys_addr, access_allowed, has_mapping};

    // checks
    `PTT_ASSERT_IMPL(a_no_accept_in_init, init_busy, !s_axis_tready, "transfer taken during table clear")
    `PTT_ASSERT_IMPL(a_unmapped_zero, m_axis_tvalid && !m_axis_tdata[0], !m_axis_tdata[1] && m_axis_tdata[33:2] == 32'd0, "unmapped result carries data")
    `PTT_ASSERT_IMPL(a_fault_not_mapped, m_axis_tvalid && m_axis_tdata[34], !m_axis_tdata[0], "fault on a translate result")

endmodule

`default_nettype wire

@@ dv/ptt_checker.sv @@
`timescale 1ns / 100ps

// item kinds carried on the input tuser bit
package ptt_tb_pkg;

    typedef enum logic {
        CMD_TRANSLATE = 1'b0,
        CMD_BUS_WRITE = 1'b1
    } t_cmd;

endpackage

module ptt_checker
    import ptt_pkg::*;
    import ptt_tb_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH    = 8192,
    parameter logic [31:0] PHYS_RAM_BASE  = 32'd33554432,
    parameter logic [31:0] CAM_BASE       = 32'd58720256,
    parameter logic [31:0] RESET_ROM_BASE = 32'd54525952
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_tvalid,
    input  logic        i_in_tready,
    // [31:0] address, [32] is_write, [33] privileged, [39:34] zero
    input  logic [39:0] i_in_tdata,
    // [0] cmd
    input  logic        i_in_tuser,
    input  logic        i_out_tvalid,
    input  logic        i_out_tready,
    // [0] has_mapping, [1] access_allowed, [33:2] phys_addr,
    // [34] test_mode_fault, [35] video_dma_on, [36] sound_dma_on, [39:37] zero
    input  logic [39:0] i_out_tdata,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic        mapped;
        logic        allowed;
        logic [31:0] phys;
        logic        fault;
        logic        video;
        logic        sound;
    } t_xlate_result;

    // shadow copy of the translator state
    logic [15:0]   page_map [TABLE_DEPTH];
    logic [1:0]    size_code;
    logic          os_on;
    logic          video_on;
    logic          sound_on;

    t_xlate_result expected_results [$];
    int            fails = 0;
    int            result_no = 0;

    // every logical page points at the rom page of the same number, level 1
    task automatic load_rom_map();
        logic [31:0] target;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            target = RESET_ROM_BASE + (32'(i) << 12) - PHYS_RAM_BASE;
            page_map[i] = {2'b01, target[25:12]};
        end
    endtask

    // physical address and protection verdict for one access
    function automatic t_xlate_result translate_access(input logic [31:0] addr,
                                                       input logic wr,
                                                       input logic priv);
        t_xlate_result r;
        int unsigned   sh;
        int unsigned   lp;
        logic [15:0]   entry;
        logic [4:0]    idx;
        r = '0;
        if ((addr & HIGH_ADDR_MASK) == 32'h0) begin
            sh        = 12 + size_code;
            lp        = (addr >> sh) % TABLE_DEPTH;
            entry     = page_map[lp];
            idx       = {wr, entry[15:14], priv, os_on};
            r.mapped  = 1'b1;
            r.allowed = PERM_MASK[idx];
            r.phys    = ({18'b0, entry[13:0]} << sh) + PHYS_RAM_BASE
                        + (addr & ((32'd1 << sh) - 32'd1));
        end
        return r;
    endfunction

    // page table entry from the scrambled bus write offset
    function automatic void write_page_entry(input logic [25:0] off);
        logic [1:0]  chip;
        logic [1:0]  level;
        logic [1:0]  high_lp;
        logic [6:0]  pp;
        logic [12:0] lp;
        chip    = {off[12], off[7]};
        level   = off[9:8];
        high_lp = off[11:10];
        case (size_code)
            2'd0: begin
                chip[1] = 1'b0;
                pp      = off[6:0];
                lp      = {high_lp, off[22:12]};
            end
            2'd1: begin
                pp = {off[0], off[6:1]};
                lp = {1'b0, high_lp, off[22:13]};
            end
            2'd2: begin
                pp = {off[1:0], off[6:2]};
                lp = {2'b0, high_lp, off[22:14]};
            end
            default: begin
                pp = {off[1], off[2], off[0], off[6:3]};
                lp = {3'b0, high_lp, off[22:15]};
            end
        endcase
        page_map[lp % TABLE_DEPTH] = {level, 5'b0, chip, pp};
    endfunction

    // controller bus write, returns the test mode fault
    function automatic logic apply_bus_write(input logic [31:0] addr);
        logic [25:0] off;
        logic        fault;
        off   = addr[25:0];
        fault = 1'b0;
        // the video chip area below the controller is left alone
        if (off >= CTRL_AREA) begin
            if ((off & CTRL_AREA_MASK) == CTRL_AREA) begin
                if (off[19:17] == CTRL_REG_SEL) begin
                    size_code = off[3:2];
                    video_on  = off[10];
                    sound_on  = off[11];
                    os_on     = off[12];
                    fault     = off[13];
                end
            end else if ({6'b0, off} >= CAM_BASE) begin
                write_page_entry(off);
            end
        end
        return fault;
    endfunction

    // predict on input transfers, compare on output transfers
    always @(posedge i_clk) begin
        t_xlate_result got;
        t_xlate_result want;
        t_xlate_result r;
        if (!i_rst_n) begin
            load_rom_map();
            size_code = 2'd0;
            os_on     = 1'b0;
            video_on  = 1'b0;
            sound_on  = 1'b0;
            expected_results.delete();
        end else begin
            if (i_out_tvalid && i_out_tready) begin
                got.mapped  = i_out_tdata[0];
                got.allowed = i_out_tdata[1];
                got.phys    = i_out_tdata[33:2];
                got.fault   = i_out_tdata[34];
                got.video   = i_out_tdata[35];
                got.sound   = i_out_tdata[36];
                if (expected_results.size() == 0) begin
                    if (fails < 10)
                        $display("result %0d arrived with nothing outstanding: %p",
                                 result_no, got);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        if (fails < 10)
                            $display("result %0d: expected %p, got %p",
                                     result_no, want, got);
                        fails++;
                    end
                end
                result_no++;
            end
            if (i_in_tvalid && i_in_tready) begin
                if (i_in_tuser == CMD_BUS_WRITE) begin
                    r       = '0;
                    r.fault = apply_bus_write(i_in_tdata[31:0]);
                end else begin
                    r = translate_access(i_in_tdata[31:0], i_in_tdata[32], i_in_tdata[33]);
                end
                r.video = video_on;
                r.sound = sound_on;
                expected_results.push_back(r);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import ptt_tb_pkg::*;

    localparam int unsigned N_RANDOM      = 500;
    // control register select with every data bit clear
    localparam logic [31:0] CTRL_REG_ADDR = 32'h036E_0000;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_HEAVY,
        STALL_PATTERN
    } t_stall_mode;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [39:0] m_axis_tdata;
    int          fail_count;
    int          pending;

    int          burst_left = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;
    logic [7:0]  stall_bits = 8'hB5;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    page_table_translator_with_protection_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ptt_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver back-pressure, switching between stall modes
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 200);
            stall_bits <= 8'($urandom);
        end else begin
            stall_left <= stall_left - 1;
            stall_bits <= {stall_bits[6:0], stall_bits[7]};
        end
        case (stall_mode)
            STALL_NONE:  m_axis_tready <= 1'b1;
            STALL_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
            STALL_HEAVY: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:     m_axis_tready <= stall_bits[0];
        endcase
    end

    // one input transfer, sent in bursts, usually with idle gaps between them
    task automatic send_item(input t_cmd cmd, input logic [31:0] addr,
                             input logic wr, input logic priv);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {6'b0, priv, wr, addr};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] a;
        int          pick;
        logic        narrow;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset mapping, range edges and addresses above 32 MB
        send_item(CMD_TRANSLATE, 32'h0000_0000, 1'b0, 1'b0);
        send_item(CMD_TRANSLATE, 32'h01FF_FFFF, 1'b1, 1'b1);
        send_item(CMD_TRANSLATE, 32'h0200_0000, 1'b0, 1'b1);
        send_item(CMD_TRANSLATE, 32'hFFFF_FFFF, 1'b1, 1'b1);
        // video area and other controller registers are ignored
        send_item(CMD_BUS_WRITE, 32'h0000_0000, 1'b1, 1'b1);
        send_item(CMD_BUS_WRITE, 32'h035F_FFFF, 1'b0, 1'b0);
        send_item(CMD_BUS_WRITE, 32'h0366_3FFF, 1'b0, 1'b1);
        // 4 KB pages, dma and os mode on, then table extremes
        send_item(CMD_BUS_WRITE, CTRL_REG_ADDR | 32'h0000_1C00, 1'b0, 1'b0);
        send_item(CMD_BUS_WRITE, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_item(CMD_TRANSLATE, 32'h01FF_F123, 1'b0, 1'b1);
        send_item(CMD_BUS_WRITE, 32'h0380_0000, 1'b0, 1'b0);
        send_item(CMD_TRANSLATE, 32'h0000_0ABC, 1'b1, 1'b0);
        // 8 KB pages with the test mode bit set
        send_item(CMD_BUS_WRITE, CTRL_REG_ADDR | 32'h0000_2804, 1'b0, 1'b0);
        send_item(CMD_BUS_WRITE, 32'h0380_357D, 1'b0, 1'b0);
        send_item(CMD_TRANSLATE, 32'h0000_1FFF, 1'b1, 1'b1);
        // 16 KB pages
        send_item(CMD_BUS_WRITE, CTRL_REG_ADDR | 32'h0000_1408, 1'b1, 1'b0);
        send_item(CMD_BUS_WRITE, 32'h03C0_6A5E, 1'b0, 1'b1);
        send_item(CMD_TRANSLATE, 32'h0000_6123, 1'b0, 1'b0);
        // 32 KB pages, everything on and test mode
        send_item(CMD_BUS_WRITE, CTRL_REG_ADDR | 32'h0000_3C0C, 1'b0, 1'b1);
        send_item(CMD_BUS_WRITE, 32'h0381_A0D5, 1'b1, 1'b1);
        send_item(CMD_TRANSLATE, 32'h0001_F0F0, 1'b1, 1'b1);
        send_item(CMD_BUS_WRITE, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send_item(CMD_TRANSLATE, 32'h0000_7FFF, 1'b0, 1'b1);
        // back to 4 KB pages with everything off
        send_item(CMD_BUS_WRITE, CTRL_REG_ADDR, 1'b0, 1'b0);
        send_item(CMD_TRANSLATE, 32'h0100_0000, 1'b0, 1'b0);

        // random mix, often narrowed to a few pages so lookups hit fresh entries
        for (int n = 0; n < N_RANDOM; n++) begin
            pick   = $urandom_range(0, 99);
            a      = $urandom;
            narrow = 1'($urandom_range(0, 1));
            if (pick < 45) begin
                if ($urandom_range(0, 99) < 85) a &= 32'h01FF_FFFF;
                if (narrow) a &= 32'h0000_3FFF;
                send_item(CMD_TRANSLATE, a, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end else if (pick < 80) begin
                a |= 32'h0380_0000;
                if (narrow) a &= ~32'h007F_CC00;
                send_item(CMD_BUS_WRITE, a, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end else if (pick < 92) begin
                a = (a & ~32'h03E0_0000) | 32'h0360_0000;
                if ($urandom_range(0, 9) != 0) a |= 32'h000E_0000;
                send_item(CMD_BUS_WRITE, a, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end else begin
                send_item(CMD_BUS_WRITE, a, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain outstanding results, then a few cycles for stragglers
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog
    initial begin
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_front.sv
hw/rtl/ptt_queue.sv
hw/rtl/ptt_back.sv
hw/rtl/page_table_translator_with_protection_top.sv
dv/ptt_checker.sv
dv/tb_top.sv
